FILE: hw/rtl/pi_controller_trapezoid_clamped_macros.svh
// -----------------------------------------------------------------------------
// PI controller assertion macros
// Shared concurrent assertion forms, clocked on rising edge, reset-qualified.
// -----------------------------------------------------------------------------
`ifndef PI_CONTROLLER_TRAPEZOID_CLAMPED_MACROS_SVH
`define PI_CONTROLLER_TRAPEZOID_CLAMPED_MACROS_SVH

// same-cycle implication
`define PITC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pitc: same-cycle check failed");

// next-cycle implication
`define PITC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pitc: next-cycle check failed");

`endif

FILE: hw/rtl/pitc_pkg.sv
// -----------------------------------------------------------------------------
// pitc_pkg
// Types, register map and reset values of the clamped PI controller.
// -----------------------------------------------------------------------------
package pitc_pkg;

	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] IDX_KP_GAIN    = 3'd0;
	localparam logic [2:0] IDX_KI_TS_GAIN = 3'd1;
	localparam logic [2:0] IDX_INTEG_MAX  = 3'd2;
	localparam logic [2:0] IDX_INTEG_MIN  = 3'd3;
	localparam logic [2:0] IDX_DRIVE_MAX  = 3'd4;
	localparam logic [2:0] IDX_DRIVE_MIN  = 3'd5;

	localparam logic [15:0]        KP_GAIN_RST    = 16'd256;
	localparam logic [15:0]        KI_TS_GAIN_RST = 16'd0;
	localparam logic signed [15:0] LIMIT_HI_RST   = 16'sd15616;
	localparam logic signed [15:0] LIMIT_LO_RST   = -16'sd15616;

	typedef struct packed {
		logic signed [15:0] setpoint;
		logic signed [15:0] measured;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               clamped;
	} result_t;

	typedef struct packed {
		logic [15:0]        kp_gain;
		logic [15:0]        ki_ts_gain;
		logic signed [15:0] integ_max;
		logic signed [15:0] integ_min;
		logic signed [15:0] drive_max;
		logic signed [15:0] drive_min;
	} cfg_t;

endpackage

FILE: hw/rtl/pitc_step.sv
// -----------------------------------------------------------------------------
// pitc_step
// One control step: error, trapezoidal integrator with clamp, P term, output clamp.
// -----------------------------------------------------------------------------
module pitc_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  pitc_pkg::sample_t sample,
	input  pitc_pkg::cfg_t   cfg,
	output pitc_pkg::result_t result
);
	import pitc_pkg::*;

	logic signed [16:0] last_err_q;
	logic signed [31:0] integ_q;

	logic signed [16:0] err;
	logic signed [17:0] err_pair;
	logic signed [34:0] inc;
	logic signed [35:0] integ_sum;
	logic signed [35:0] imax_w;
	logic signed [35:0] imin_w;
	logic signed [35:0] integ_sat;
	logic signed [33:0] prop;
	logic signed [34:0] total;
	logic signed [26:0] val;
	logic signed [26:0] dmax_w;
	logic signed [26:0] dmin_w;

	always_comb begin
		err      = {sample.setpoint[15], sample.setpoint} - {sample.measured[15], sample.measured};
		err_pair = {err[16], err} + {last_err_q[16], last_err_q};
		inc      = $signed({1'b0, cfg.ki_ts_gain}) * err_pair;
		integ_sum = {{4{integ_q[31]}}, integ_q} + {inc[34], inc};

		// limits are Q8.8, integrator is Q8.24
		imax_w = {{4{cfg.integ_max[15]}}, cfg.integ_max, 16'b0};
		imin_w = {{4{cfg.integ_min[15]}}, cfg.integ_min, 16'b0};
		if (integ_sum >= imax_w) begin
			integ_sat = imax_w;
		end else if (integ_sum <= imin_w) begin
			integ_sat = imin_w;
		end else begin
			integ_sat = integ_sum;
		end

		prop  = $signed({1'b0, cfg.kp_gain}) * err;
		// floor shifts: drop 8 LSBs of integrator, then 8 LSBs of the sum
		total = {prop[33], prop} + {{11{integ_sat[31]}}, integ_sat[31:8]};
		val   = total[34:8];

		dmax_w = {{11{cfg.drive_max[15]}}, cfg.drive_max};
		dmin_w = {{11{cfg.drive_min[15]}}, cfg.drive_min};
		if (val >= dmax_w) begin
			result.drive   = cfg.drive_max;
			result.clamped = 1'b1;
		end else if (val <= dmin_w) begin
			result.drive   = cfg.drive_min;
			result.clamped = 1'b1;
		end else begin
			result.drive   = val[15:0];
			result.clamped = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			integ_q    <= '0;
		end else if (step) begin
			last_err_q <= err;
			integ_q    <= integ_sat[31:0];
		end
	end

endmodule

FILE: hw/rtl/pi_controller_trapezoid_clamped.sv
// -----------------------------------------------------------------------------
// pi_controller_trapezoid_clamped: PI controller, trapezoidal integrator, clamping
// Datapath: an accepted sample goes into the input reg, then is stepped into the result reg.
// Throughput: one request per cycle while results are taken; result back-pressure holds it.
// Reset (arst_n low): pipeline empty, integrator and last error zero, registers at defaults.
// -----------------------------------------------------------------------------
`include "pi_controller_trapezoid_clamped_macros.svh"

module pi_controller_trapezoid_clamped (
	input  logic                               clk,
	input  logic                               arst_n,
	// sample channel
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  pitc_pkg::sample_t                  sample,
	// result channel
	output logic                               result_valid,
	input  logic                               result_ready,
	output pitc_pkg::result_t                  result,
	// configuration port
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pitc_pkg::AddrWidth-1:0]     paddr,
	input  logic [pitc_pkg::DataWidth-1:0]     pwdata,
	output logic [pitc_pkg::DataWidth-1:0]     prdata,
	output logic                               pready
);
	import pitc_pkg::*;

	// ---------------------------------------------------------------------
	// Config registers: the user writes them only while the controller is
	// idle; the block does not enforce it. Step logic reads them directly.
	// ---------------------------------------------------------------------
	cfg_t       cfg_q;
	logic       cfg_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain    <= KP_GAIN_RST;
			cfg_q.ki_ts_gain <= KI_TS_GAIN_RST;
			cfg_q.integ_max  <= LIMIT_HI_RST;
			cfg_q.integ_min  <= LIMIT_LO_RST;
			cfg_q.drive_max  <= LIMIT_HI_RST;
			cfg_q.drive_min  <= LIMIT_LO_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				IDX_KP_GAIN:    cfg_q.kp_gain    <= pwdata[15:0];
				IDX_KI_TS_GAIN: cfg_q.ki_ts_gain <= pwdata[15:0];
				IDX_INTEG_MAX:  cfg_q.integ_max  <= pwdata[15:0];
				IDX_INTEG_MIN:  cfg_q.integ_min  <= pwdata[15:0];
				IDX_DRIVE_MAX:  cfg_q.drive_max  <= pwdata[15:0];
				IDX_DRIVE_MIN:  cfg_q.drive_min  <= pwdata[15:0];
				default: ; // unmapped index: write dropped
			endcase
		end
	end

	// read mux; signed limits come back sign-extended
	always_comb begin
		unique case (reg_idx)
			IDX_KP_GAIN:    prdata = {16'b0, cfg_q.kp_gain};
			IDX_KI_TS_GAIN: prdata = {16'b0, cfg_q.ki_ts_gain};
			IDX_INTEG_MAX:  prdata = {{16{cfg_q.integ_max[15]}}, cfg_q.integ_max};
			IDX_INTEG_MIN:  prdata = {{16{cfg_q.integ_min[15]}}, cfg_q.integ_min};
			IDX_DRIVE_MAX:  prdata = {{16{cfg_q.drive_max[15]}}, cfg_q.drive_max};
			IDX_DRIVE_MIN:  prdata = {{16{cfg_q.drive_min[15]}}, cfg_q.drive_min};
			default:        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Two-stage pipe: stage 1 holds the accepted sample, stage 2 the
	// result. Stage 1 moves into stage 2 (and commits the controller
	// state) whenever stage 2 is empty or being drained, so a new request
	// is taken every cycle while results are taken. A waiting result
	// leaves room for one more request in stage 1.
	// ---------------------------------------------------------------------
	logic    valid_s1;
	sample_t sample_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t step_result;
	logic    adv;

	assign adv          = valid_s1 & (~valid_s2 | result_ready);
	assign sample_ready = ~valid_s1 | adv;
	assign result_valid = valid_s2;
	assign result       = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample_ready) begin
				valid_s1 <= sample_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid & sample_ready) begin
			sample_s1 <= sample;
		end
		if (adv) begin
			result_s2 <= step_result;
		end
	end

	// integrator and last error live in the step unit and update on adv
	pitc_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.sample (sample_s1),
		.cfg    (cfg_q),
		.result (step_result)
	);

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	`PITC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, sample_valid && sample_ready, valid_s1)
	`PITC_ASSERT_NEXT(a_adv_fills_s2, clk, arst_n, adv, valid_s2)
	`PITC_ASSERT_NEXT(a_s1_holds_on_stall, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(sample_s1))
	`PITC_ASSERT_NOW(a_no_adv_on_stall, clk, arst_n, valid_s2 && !result_ready, !adv)

endmodule

FILE: verif/tb_pi_controller_trapezoid_clamped.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_pi_controller_trapezoid_clamped: self-checking bench for the clamped PI loop
// Sends setpoint/measured requests through valid/ready with random gaps on both
// sides. Each drive/clamped result is checked against a bit-exact predictor that
// runs alongside, or against the typed value in the table for pinned rows. The
// gains and limits are reprogrammed over APB between phases and read back.
// -----------------------------------------------------------------------------
module tb_pi_controller_trapezoid_clamped;
	import pitc_pkg::*;

	localparam int CLK_HI       = 6;
	localparam int CLK_LO       = 6;
	localparam int RESET_CYCLES = 4;
	localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all
	localparam int DRAIN_CYCLES = 4;     // pipeline is two deep, plus margin
	localparam int NUM_PHASES   = 7;
	localparam int PHASE_ITEMS  = 150;

	// unmapped register slots, writes there must be dropped
	localparam logic [2:0] IDX_SPARE_LO = 3'd6;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;
	localparam int NO_WRITE = -1;        // directed rows that run on reset values

	typedef struct {
		bit      pinned;   // expectation typed in the table
		result_t value;
	} known_t;

	typedef struct {
		int      setting;
		sample_t req;
		bit      pinned;
		result_t value;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 sample_valid;
	logic                 sample_ready;
	sample_t              sample;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [AddrWidth-1:0] paddr;
	logic [DataWidth-1:0] pwdata;
	logic [DataWidth-1:0] prdata;
	logic                 pready;

	// predictor state and register shadow
	cfg_t               cfg_shadow;
	logic signed [16:0] last_err_q;
	logic signed [31:0] integ_q;

	result_t  expected_drive_q[$];
	known_t   known_drive_q[$];
	dir_row_t dir_rows[$];
	cfg_t     phase_cfg[NUM_PHASES];

	int send_idle_pct;
	int recv_idle_pct;
	int fault_count;
	int stall_cycles;

	pi_controller_trapezoid_clamped u_dut (
		.clk,
		.arst_n,
		.sample_valid,
		.sample_ready,
		.sample,
		.result_valid,
		.result_ready,
		.result,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready
	);

	always begin
		clk = 1'b0;
		#(CLK_LO);
		clk = 1'b1;
		#(CLK_HI);
	end

	// ---------------------------------------------------------------------
	// Predictor: one control step per accepted request.
	// error is Q9.8, integrator Q8.24, products kept exact in 64 bits;
	// >>> on a signed longint floors, which is the rounding wanted here.
	// ---------------------------------------------------------------------
	function automatic result_t pi_step(input sample_t req);
		longint  err;
		longint  acc;
		longint  lim_hi;
		longint  lim_lo;
		longint  total;
		longint  level;
		result_t r;
		err    = longint'($signed(req.setpoint)) - longint'($signed(req.measured));
		acc    = longint'(integ_q)
			+ longint'(cfg_shadow.ki_ts_gain) * (err + longint'(last_err_q));
		lim_hi = longint'($signed(cfg_shadow.integ_max)) <<< 16;
		lim_lo = longint'($signed(cfg_shadow.integ_min)) <<< 16;
		// upper limit wins when the limits are crossed
		if (acc >= lim_hi) begin
			acc = lim_hi;
		end else if (acc <= lim_lo) begin
			acc = lim_lo;
		end
		total = longint'(cfg_shadow.kp_gain) * err + (acc >>> 8);
		level = total >>> 8;
		// touching a limit counts as clamping
		r.clamped = 1'b1;
		if (level >= longint'($signed(cfg_shadow.drive_max))) begin
			level = longint'($signed(cfg_shadow.drive_max));
		end else if (level <= longint'($signed(cfg_shadow.drive_min))) begin
			level = longint'($signed(cfg_shadow.drive_min));
		end else begin
			r.clamped = 1'b0;
		end
		last_err_q = 17'(err);
		integ_q    = 32'(acc);
		r.drive    = 16'(level);
		return r;
	endfunction

	function automatic dir_row_t mk_row(input int setting, input logic signed [15:0] sp,
			input logic signed [15:0] ms, input bit pinned, input logic signed [15:0] drv,
			input bit clp);
		dir_row_t row;
		row.setting          = setting;
		row.req.setpoint     = sp;
		row.req.measured     = ms;
		row.pinned           = pinned;
		row.value.drive      = drv;
		row.value.clamped    = clp;
		return row;
	endfunction

	function automatic logic [15:0] corner_value();
		case ($urandom_range(3))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			default: return 16'hFFFF;
		endcase
	endfunction

	// mix of full-range errors, small errors around a random point and corners
	function automatic sample_t rand_sample();
		sample_t     req;
		int unsigned pick;
		pick         = $urandom_range(99);
		req.setpoint = 16'($urandom());
		if (pick < 50) begin
			req.measured = 16'($urandom());
		end else if (pick < 85) begin
			req.measured = req.setpoint + 16'($urandom_range(1023)) - 16'd512;
		end else begin
			req.setpoint = corner_value();
			req.measured = corner_value();
		end
		return req;
	endfunction

	// ordered limit pair, crossed now and then
	function automatic void rand_limits(output logic signed [15:0] hi,
			output logic signed [15:0] lo);
		logic signed [15:0] a;
		logic signed [15:0] b;
		a = 16'($urandom());
		b = 16'($urandom());
		if (a < b) begin
			hi = b;
			lo = a;
		end else begin
			hi = a;
			lo = b;
		end
		if ($urandom_range(4) == 0) begin
			a  = hi;
			hi = lo;
			lo = a;
		end
	endfunction

	function automatic cfg_t rand_settings();
		cfg_t c;
		c.kp_gain    = $urandom_range(1) ? 16'($urandom_range(1023)) : 16'($urandom());
		c.ki_ts_gain = $urandom_range(1) ? 16'($urandom_range(4095)) : 16'($urandom());
		rand_limits(c.integ_max, c.integ_min);
		rand_limits(c.drive_max, c.drive_min);
		return c;
	endfunction

	// ---------------------------------------------------------------------
	// APB access; called at a falling edge, returns at a falling edge.
	// psel stays up between back-to-back accesses, dropped by the caller.
	// ---------------------------------------------------------------------
	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= AddrWidth'({idx, 2'b00});
		pwdata  <= {16'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			IDX_KP_GAIN:    cfg_shadow.kp_gain    = value;
			IDX_KI_TS_GAIN: cfg_shadow.ki_ts_gain = value;
			IDX_INTEG_MAX:  cfg_shadow.integ_max  = value;
			IDX_INTEG_MIN:  cfg_shadow.integ_min  = value;
			IDX_DRIVE_MAX:  cfg_shadow.drive_max  = value;
			IDX_DRIVE_MIN:  cfg_shadow.drive_min  = value;
			default: ;  // unmapped, dropped
		endcase
		@(negedge clk);
	endtask

	task automatic cfg_check(input logic [2:0] idx);
		logic [15:0] want;
		case (idx)
			IDX_KP_GAIN:    want = cfg_shadow.kp_gain;
			IDX_KI_TS_GAIN: want = cfg_shadow.ki_ts_gain;
			IDX_INTEG_MAX:  want = cfg_shadow.integ_max;
			IDX_INTEG_MIN:  want = cfg_shadow.integ_min;
			IDX_DRIVE_MAX:  want = cfg_shadow.drive_max;
			default:        want = cfg_shadow.drive_min;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= AddrWidth'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// only the low half is defined, upper bits may be an extension
		if (prdata[15:0] !== want) begin
			$display("%0t readback reg %0d: expected %h, actual %h",
				$time, idx, want, prdata[15:0]);
			fault_count++;
		end
		@(negedge clk);
	endtask

	// everything answered, then let the pipe settle
	task automatic wait_drained();
		while (expected_drive_q.size() != 0 || known_drive_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		sample_valid <= 1'b0;
		wait_drained();
		cfg_write(IDX_KP_GAIN, c.kp_gain);
		cfg_write(IDX_KI_TS_GAIN, c.ki_ts_gain);
		cfg_write(IDX_INTEG_MAX, c.integ_max);
		cfg_write(IDX_INTEG_MIN, c.integ_min);
		cfg_write(IDX_DRIVE_MAX, c.drive_max);
		cfg_write(IDX_DRIVE_MIN, c.drive_min);
		// junk at the unmapped slots must not land anywhere
		cfg_write(IDX_SPARE_LO, 16'($urandom()));
		cfg_write(IDX_SPARE_HI, 16'($urandom()));
		for (int i = 0; i < 6; i++) begin
			cfg_check(3'(i));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// one request; valid is left high so the next one can follow back to back
	task automatic send_sample(input sample_t req, input bit pinned, input result_t value);
		known_t k;
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		k.pinned = pinned;
		k.value  = value;
		known_drive_q.push_back(k);
		sample_valid <= 1'b1;
		sample       <= req;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// result side backpressure, redrawn every cycle
	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Scoreboard: results checked first, so a same-edge request only queues
	// behind the older ones.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		result_t want;
		known_t  k;
		if (result_valid && result_ready) begin
			if (expected_drive_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual drive %0d clamped %0b",
					$time, result.drive, result.clamped);
				fault_count++;
			end else begin
				want = expected_drive_q.pop_front();
				if (result.drive !== want.drive || result.clamped !== want.clamped) begin
					$display("%0t mismatch: expected drive %0d clamped %0b, actual drive %0d clamped %0b",
						$time, want.drive, want.clamped, result.drive, result.clamped);
					fault_count++;
				end
			end
		end
		if (sample_valid && sample_ready) begin
			// predictor always steps so its state follows the block
			want = pi_step(sample);
			k    = known_drive_q.pop_front();
			if (k.pinned) begin
				want = k.value;
			end
			expected_drive_q.push_back(want);
		end
	end

	// watchdog: any handshake on any port counts as progress
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready)
				|| (psel && penable)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int cur_set;
		arst_n        = 1'b0;
		sample_valid  = 1'b0;
		sample        = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fault_count   = 0;
		stall_cycles  = 0;
		cfg_shadow    = '{KP_GAIN_RST, KI_TS_GAIN_RST, LIMIT_HI_RST, LIMIT_LO_RST,
			LIMIT_HI_RST, LIMIT_LO_RST};
		last_err_q    = '0;
		integ_q       = '0;

		// fixed phase settings: moderate, all-max, all-zero, crossed limits
		phase_cfg[0] = '{16'd256, 16'd1000, LIMIT_HI_RST, LIMIT_LO_RST,
			LIMIT_HI_RST, LIMIT_LO_RST};
		phase_cfg[1] = '{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
		phase_cfg[2] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
		phase_cfg[3] = '{16'd384, 16'd2000, -16'sd2560, 16'sd2560, -16'sd1280, 16'sd1280};
		for (int p = 4; p < NUM_PHASES; p++) begin
			phase_cfg[p] = rand_settings();
		end

		// Reset values: ki is zero, kp is 1.0, so drive is the error clamped
		// to +-61.0 and can be typed in directly.
		dir_rows.push_back(mk_row(NO_WRITE, 16'sd0, 16'sd0, 1, 16'sd0, 0));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sh7FFF, 16'sh8000, 1, 16'sd15616, 1));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sh8000, 16'sh7FFF, 1, -16'sd15616, 1));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sd15616, 16'sd0, 1, 16'sd15616, 1));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sd15615, 16'sd0, 1, 16'sd15615, 0));
		dir_rows.push_back(mk_row(NO_WRITE, -16'sd15616, 16'sd0, 1, -16'sd15616, 1));
		dir_rows.push_back(mk_row(NO_WRITE, -16'sd15615, 16'sd0, 1, -16'sd15615, 0));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sd0, -16'sd15616, 1, 16'sd15616, 1));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sh7FFF, 16'sh7FFF, 1, 16'sd0, 0));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sh8000, 16'sh8000, 1, 16'sd0, 0));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sd1, 16'sd0, 1, 16'sd1, 0));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sd0, 16'sd1, 1, -16'sd1, 0));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sh8000, 16'sd0, 1, -16'sd15616, 1));
		dir_rows.push_back(mk_row(NO_WRITE, 16'sh7FFF, 16'sd0, 1, 16'sd15616, 1));
		// max gains, full-range limits: integrator slams rail to rail
		dir_rows.push_back(mk_row(1, 16'sh7FFF, 16'sh8000, 0, 16'sd0, 0));
		dir_rows.push_back(mk_row(1, 16'sh8000, 16'sh7FFF, 0, 16'sd0, 0));
		dir_rows.push_back(mk_row(1, 16'sh8000, 16'sh7FFF, 0, 16'sd0, 0));
		dir_rows.push_back(mk_row(1, 16'sd0, 16'sd0, 0, 16'sd0, 0));
		dir_rows.push_back(mk_row(1, 16'sd1, 16'sd0, 0, 16'sd0, 0));
		dir_rows.push_back(mk_row(1, -16'sd1, 16'sd0, 0, 16'sd0, 0));
		// crossed limits: lower limit above upper
		dir_rows.push_back(mk_row(3, 16'sd0, 16'sd0, 0, 16'sd0, 0));
		dir_rows.push_back(mk_row(3, 16'sd1000, -16'sd1000, 0, 16'sd0, 0));
		dir_rows.push_back(mk_row(3, -16'sd1000, 16'sd1000, 0, 16'sd0, 0));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling
		cur_set = NO_WRITE;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].setting != cur_set) begin
				cur_set = dir_rows[i].setting;
				load_settings(phase_cfg[cur_set]);
			end
			send_sample(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].value);
		end

		// random phases: sender light / receiver heavy idling, then swapped, then none
		for (int p = 0; p < NUM_PHASES; p++) begin
			load_settings(phase_cfg[p]);
			if (p < 2) begin
				send_idle_pct = 30;
				recv_idle_pct = 88;
			end else if (p < 4) begin
				send_idle_pct = 88;
				recv_idle_pct = 30;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			repeat (PHASE_ITEMS) send_sample(rand_sample(), 1'b0, '0);
		end

		sample_valid <= 1'b0;
		wait_drained();
		if (fault_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
